// ===== sv/wsfd_pkg.sv =====
`timescale 1ns / 1ps

package wsfd_pkg;

    // Queue between the parser and the output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Header field layout
    localparam logic [7:0] OPCODE_MASK   = 8'h0F;
    localparam logic [7:0] MASK_FLAG     = 8'h80;
    localparam logic [7:0] LEN7_MASK     = 8'h7F;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [3:0] KEY_BYTES     = 4'd4;
    localparam logic [15:0] MAX_LEN_RST  = 16'd8176;
    localparam int CFG_W                 = 16;

    // One classified result on its way to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       last;
        logic       payload;
        logic       err;
    } wsfd_item_t;

endpackage

// ===== sv/wsfd_front.sv =====
`timescale 1ns / 1ps

module wsfd_front #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wsfd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte,
    input  logic                        in_restart,
    input  logic                        q_full,
    output logic                        push,
    output wsfd_pkg::wsfd_item_t        push_item
);
    import wsfd_pkg::*;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    logic [CFG_W-1:0]       max_len_reg;
    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   mask_reg, mask_next;
    logic [3:0]             ext_reg, ext_next;
    logic [LENGTH_BITS-1:0] dlen_reg, dlen_next;
    logic [15:0]            rem_reg, rem_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             kidx_reg, kidx_next;
    logic                   ovf_reg, ovf_next;

    logic                   accept;
    logic                   do_len_done;
    logic                   do_begin;
    logic [LENGTH_BITS-1:0] ld_len;
    logic                   ld_ovf;
    logic                   ld_mask;
    logic [LENGTH_BITS-1:0] bp_len;
    logic [7:0]             key_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;

    // Key byte for the current payload position, most significant first
    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Header parser
    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        ext_next    = ext_reg;
        dlen_next   = dlen_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        ovf_next    = ovf_reg;
        do_len_done = 1'b0;
        do_begin    = 1'b0;
        ld_len      = dlen_reg;
        ld_ovf      = ovf_reg;
        ld_mask     = mask_reg;
        bp_len      = dlen_reg;
        push        = 1'b0;
        push_item         = '0;
        push_item.opcode  = opcode_reg;

        if (accept)
        begin
            if (in_restart)
            begin
                phase_next = PH_HDR0;
                ext_next   = '0;
                rem_next   = '0;
                kidx_next  = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR1:
                    begin
                        mask_next = (in_byte & MASK_FLAG) != 8'd0;
                        key_next  = '0;
                        ovf_next  = 1'b0;
                        if (in_byte[6:0] == LEN_EXT16)
                        begin
                            dlen_next  = '0;
                            ext_next   = EXT16_BYTES;
                            phase_next = PH_EXT;
                        end
                        else if (in_byte[6:0] == LEN_EXT64)
                        begin
                            dlen_next  = '0;
                            ext_next   = EXT64_BYTES;
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            dlen_next   = LENGTH_BITS'(in_byte & LEN7_MASK);
                            do_len_done = 1'b1;
                            ld_len      = dlen_next;
                            ld_ovf      = 1'b0;
                            ld_mask     = mask_next;
                        end
                    end
                    PH_EXT:
                    begin
                        ovf_next  = ovf_reg ||
                                    (dlen_reg[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0);
                        dlen_next = {dlen_reg[LENGTH_BITS-9:0], in_byte};
                        ext_next  = ext_reg - 4'd1;
                        if (ext_next == 4'd0)
                        begin
                            do_len_done = 1'b1;
                            ld_len      = dlen_next;
                            ld_ovf      = ovf_next;
                            ld_mask     = mask_reg;
                        end
                    end
                    PH_MASK:
                    begin
                        key_next = {key_reg[23:0], in_byte};
                        ext_next = ext_reg - 4'd1;
                        if (ext_next == 4'd0)
                        begin
                            do_begin = 1'b1;
                            bp_len   = dlen_reg;
                        end
                    end
                    PH_DATA:
                    begin
                        kidx_next         = kidx_reg + 2'd1;
                        rem_next          = rem_reg - 16'd1;
                        push              = 1'b1;
                        push_item.data    = in_byte;
                        push_item.key     = key_byte;
                        push_item.payload = 1'b1;
                        if (rem_reg == 16'd1)
                        begin
                            push_item.last = 1'b1;
                            phase_next     = PH_HDR0;
                        end
                    end
                    PH_HALT:
                    begin
                        phase_next = PH_HALT;
                    end
                    default:
                    begin
                        opcode_next = in_byte[3:0] & OPCODE_MASK[3:0];
                        phase_next  = PH_HDR1;
                    end
                endcase

                // Length complete: limit check, then key or payload
                if (do_len_done)
                begin
                    if (ld_ovf || (ld_len > LENGTH_BITS'(max_len_reg)))
                    begin
                        phase_next    = PH_HALT;
                        push          = 1'b1;
                        push_item.err = 1'b1;
                    end
                    else if (ld_mask)
                    begin
                        ext_next   = KEY_BYTES;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        do_begin = 1'b1;
                        bp_len   = ld_len;
                    end
                end

                // Payload start; an empty frame gives one end marker
                if (do_begin)
                begin
                    if (bp_len == '0)
                    begin
                        phase_next     = PH_HDR0;
                        push           = 1'b1;
                        push_item.last = 1'b1;
                    end
                    else
                    begin
                        rem_next   = bp_len[15:0];
                        kidx_next  = '0;
                        phase_next = PH_DATA;
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RST;
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            ext_reg     <= '0;
            dlen_reg    <= '0;
            rem_reg     <= '0;
            key_reg     <= '0;
            kidx_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_len_reg <= cfg_data;
            end
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            ext_reg    <= ext_next;
            dlen_reg   <= dlen_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ===== sv/wsfd_queue.sv =====
`timescale 1ns / 1ps

module wsfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wsfd_pkg::wsfd_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output wsfd_pkg::wsfd_item_t  head_item
);
    import wsfd_pkg::*;

    wsfd_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full       = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = slot_reg[rd_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overrun");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue underrun");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== sv/wsfd_back.sv =====
`timescale 1ns / 1ps

module wsfd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  wsfd_pkg::wsfd_item_t  head_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_data,
    output logic                  out_pvalid,
    output logic [3:0]            out_op,
    output logic                  out_last,
    output logic                  out_err
);
    import wsfd_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       payload_reg;
    logic [3:0] opcode_reg;
    logic       last_reg;
    logic       err_reg;

    // Take the next item when the output register is free or draining
    assign pop = head_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= head_valid;
        end
    end

    // Unmask and register the result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg    <= head_item.data ^ head_item.key;
            payload_reg <= head_item.payload;
            opcode_reg  <= head_item.opcode;
            last_reg    <= head_item.last;
            err_reg     <= head_item.err;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_pvalid = payload_reg;
    assign out_op     = opcode_reg;
    assign out_last   = last_reg;
    assign out_err    = err_reg;

endmodule

// ===== sv/websocket_frame_decoder.sv =====
`timescale 1ns / 1ps
// WebSocket receive deframer.
// Input stream: one received byte per transaction on s_tdata; s_tuser high
// drops any partial frame, clears a length error and returns to the header
// (the byte is ignored and gives no result).
// Output stream: one transaction per payload byte (unmasked), one marker
// for an empty frame (m_tlast high, payload flag low) and one error marker
// when the declared length exceeds max_payload_len; after an error, bytes
// are dropped until restart. Header and mask key bytes give no output.
// cfg_valid/cfg_data writes max_payload_len (reset 8176); cfg_ready is
// always high. Write it only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. An accepted
// byte is written into the queue, then moved into the output register
// once that register is free or draining; its result is then on the m side.
// A four-entry queue sits between parser and output register; when the
// receiver holds m_tready low the queue fills and s_tready then drops.
// Reset (rst_n low, asynchronous) empties the queue and the output and
// returns the parser to header byte zero.
module websocket_frame_decoder #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wsfd_pkg::CFG_W-1:0]  cfg_data,    // max_payload_len
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // [7:0] rx_byte
    input  logic                        s_tuser,     // [0] restart
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,     // [7:0] data_byte
    output logic [5:0]                  m_tuser,     // [0] payload_valid,
                                                     // [4:1] frame_opcode,
                                                     // [5] length_error
    output logic                        m_tlast      // frame_end
);
    import wsfd_pkg::*;

    logic       q_full;
    logic       push;
    wsfd_item_t push_item;
    logic       pop;
    logic       head_valid;
    wsfd_item_t head_item;
    logic       res_pvalid;
    logic [3:0] res_op;
    logic       out_err;

    wsfd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_restart (s_tuser),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    wsfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    wsfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_pvalid  (res_pvalid),
        .out_op      (res_op),
        .out_last    (m_tlast),
        .out_err     (out_err)
    );

    assign m_tuser = {out_err, res_op, res_pvalid};

endmodule
